/* src/lsmf_pkg.sv */
// shared constants, register codes and the control struct for the limiting mean filter
// no dependencies; compiled first
package lsmf_pkg;

  // parameter defaults
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 12;

  // configuration register layout
  localparam int LIMIT_BITS     = 12;
  localparam int WL_BITS        = 7;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LIMIT   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CFG_INDEX_BITS'(1);

  localparam logic [LIMIT_BITS-1:0] RESET_RANGE_LIMIT   = LIMIT_BITS'(100);
  localparam logic [WL_BITS-1:0]    RESET_WINDOW_LENGTH = WL_BITS'(8);

  // controls from the sequencer to the window memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } ring_ctrl_t;

endpackage

/* src/lsmf_if.sv */
// valid/ready channel interfaces for samples in and means out
// no dependencies
interface lsmf_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lsmf_mean_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_mean;

  modport source (output valid, output filtered_mean, input ready);
  modport sink (input valid, input filtered_mean, output ready);
endinterface

/* src/limited_sliding_mean_filter_unit.sv */
// top level of the limiting moving-average filter: sequencer, registers, ring and divider
// depends on lsmf_pkg, lsmf_if, lsmf_ring, lsmf_div
//
//   port        dir     role
//   samples     sink    one converter sample per item
//   means       source  truncated window mean, one per non-priming sample
//   cfg_*       in      register writes: 0 range_limit, 1 window_length
//
// a non-priming item goes through accept and ring read, then read-modify-write of the ring and total,
// then the divider's one bit per cycle until it reports done, then the output register load.
// a priming item only loads the reference value and yields no mean.
// after reset and every window_length write, the clearing sweep over all MAX_WINDOW ring slots
// holds samples.ready low. a stalled result sits in the output register while the
// next sample is accepted; the sequencer waits there only if that register is still full.
module limited_sliding_mean_filter_unit #(
  parameter int MAX_WINDOW  = lsmf_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = lsmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  lsmf_sample_if.sink                         samples,
  lsmf_mean_if.source                         means,
  input  logic                                cfg_write,
  input  logic [lsmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lsmf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lsmf_pkg::*;

  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int CMP_BITS   = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_OUT    = 3'd3;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [LIMIT_BITS-1:0]  range_limit;
  logic [WL_BITS-1:0]     window_length;
  logic                   primed;
  logic [SAMPLE_BITS-1:0] reference_value;
  logic [SLOT_BITS-1:0]   write_slot;
  logic [TOTAL_BITS-1:0]  running_total;
  logic [TOTAL_BITS-1:0]  running_total_next;
  logic [SLOT_BITS-1:0]   slot;
  logic [SAMPLE_BITS-1:0] stored;

  logic                   accept;
  logic                   win_write;
  logic [WL_BITS-1:0]     eff_len;
  logic [SLOT_BITS-1:0]   slot_cur;
  logic [SLOT_BITS:0]     slot_inc;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   over_limit;
  logic                   out_load;

  ring_ctrl_t             ring_ctrl;
  logic [SLOT_BITS-1:0]   ring_addr;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic                   ring_clearing;
  logic                   div_busy;
  logic [TOTAL_BITS-1:0]  div_quotient;

  // handshake
  assign samples.ready = (state == ST_IDLE) && !ring_clearing;
  assign accept        = samples.valid && samples.ready;
  assign win_write     = cfg_write && (cfg_index == REG_WINDOW_LENGTH);

  // effective window length saturates to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      eff_len = WL_BITS'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      eff_len = WL_BITS'(MAX_WINDOW);
    end else begin
      eff_len = window_length;
    end
  end

  // slot for this item and the one after it
  assign slot_cur = (int'(write_slot) >= int'(eff_len)) ? '0 : write_slot;
  assign slot_inc = {1'b0, slot} + (SLOT_BITS + 1)'(1);

  // limit check against the reference
  assign diff = (samples.sample >= reference_value) ? samples.sample - reference_value
                                                    : reference_value - samples.sample;
  assign over_limit = CMP_BITS'(diff) > CMP_BITS'(range_limit);

  // ring total after replacing the old slot value
  assign running_total_next = running_total - TOTAL_BITS'(ring_rdata) + TOTAL_BITS'(stored);

  // ring access
  assign ring_ctrl.rd_en = accept && primed;
  assign ring_ctrl.wr_en = (state == ST_UPDATE);
  assign ring_ctrl.clear = win_write;
  assign ring_addr       = (state == ST_IDLE) ? slot_cur : slot;

  // output register load
  assign out_load = (state == ST_OUT) && (!means.valid || means.ready);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && primed) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit   <= RESET_RANGE_LIMIT;
      window_length <= RESET_WINDOW_LENGTH;
    end else if (cfg_write) begin
      if (cfg_index == REG_RANGE_LIMIT) begin
        range_limit <= cfg_data[LIMIT_BITS-1:0];
      end else if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data[WL_BITS-1:0];
      end
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst || win_write) begin
      primed        <= 1'b0;
      write_slot    <= '0;
      running_total <= '0;
      if (rst) begin
        reference_value <= '0;
      end
    end else if (accept) begin
      if (!primed) begin
        primed          <= 1'b1;
        reference_value <= samples.sample;
      end else if (!over_limit) begin
        reference_value <= samples.sample;
      end
    end else if (state == ST_UPDATE) begin
      running_total <= running_total_next;
      if (int'(slot_inc) >= int'(eff_len)) begin
        write_slot <= '0;
      end else begin
        write_slot <= slot_inc[SLOT_BITS-1:0];
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slot   <= slot_cur;
      stored <= over_limit ? reference_value : samples.sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      means.valid <= 1'b0;
    end else if (out_load) begin
      means.valid <= 1'b1;
    end else if (means.ready) begin
      means.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      means.filtered_mean <= div_quotient[SAMPLE_BITS-1:0];
    end
  end

  lsmf_ring #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .addr    (ring_addr),
    .wdata   (stored),
    .rdata   (ring_rdata),
    .clearing(ring_clearing)
  );

  lsmf_div #(
    .DIVIDEND_BITS(TOTAL_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_UPDATE),
    .dividend(running_total_next),
    .divisor (eff_len),
    .busy    (div_busy),
    .quotient(div_quotient)
  );

  // no samples taken while the ring is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    ring_clearing |-> !samples.ready)
    else $error("sample accepted during ring clearing");

  // a primed item goes straight to the ring update
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (accept && primed && !win_write) |=> (state == ST_UPDATE))
    else $error("accepted item did not reach ring update");

  // the divider is running for the whole first divide cycle
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> div_busy)
    else $error("divider not started on ring update");

  // an output load always presents a result next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (means.valid && state == ST_IDLE))
    else $error("result load lost");

  // the ring is never written by an item while it is being cleared
  a_no_write_clearing: assert property (@(posedge clk) disable iff (rst)
    ring_ctrl.wr_en |-> !ring_clearing)
    else $error("ring item write during clearing");

endmodule

/* src/lsmf_ring.sv */
// window ring memory: one port, registered read, clearing sweep after reset or on request
// depends on lsmf_pkg
module lsmf_ring #(
  parameter int MAX_WINDOW  = lsmf_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = lsmf_pkg::DEF_SAMPLE_BITS,
  parameter int SLOT_BITS   = $clog2(MAX_WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lsmf_pkg::ring_ctrl_t   ctrl,
  input  logic [SLOT_BITS-1:0]   addr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  output logic [SAMPLE_BITS-1:0] rdata,
  output logic                   clearing
);
  import lsmf_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_WINDOW - 1);

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SLOT_BITS-1:0]   clr_addr;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_SLOT) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + SLOT_BITS'(1);
    end
  end

  // memory write: sweep zeros or store the new item value
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctrl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/lsmf_div.sv */
// restoring divider, one quotient bit per cycle, for the window total over the length
// depends on lsmf_pkg
module lsmf_div #(
  parameter int DIVIDEND_BITS = 19
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [DIVIDEND_BITS-1:0]         dividend,
  input  logic [lsmf_pkg::WL_BITS-1:0]     divisor,
  output logic                             busy,
  output logic [DIVIDEND_BITS-1:0]         quotient
);
  import lsmf_pkg::*;

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [WL_BITS-1:0]  rem;
  logic [WL_BITS-1:0]  dvs;
  logic [CNT_BITS-1:0] count;
  logic [WL_BITS:0]    shifted;
  logic                fits;

  // trial subtraction for the current bit
  assign shifted = {rem, quotient[DIVIDEND_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(DIVIDEND_BITS);
    end else if (busy) begin
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
      count <= count - CNT_BITS'(1);
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= WL_BITS'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[WL_BITS-1:0];
      end
      quotient <= {quotient[DIVIDEND_BITS-2:0], fits};
    end
  end

endmodule
